// ===== src/rc4v_pkg.sv =====
package rc4v_pkg;

    localparam int MAX_KEY_BYTES = 16;
    localparam int KS_MODULUS    = 246;

    localparam logic OP_INIT    = 1'b0;
    localparam logic OP_ENCRYPT = 1'b1;

    localparam logic [1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [1:0] REG_KEY_LEN  = 2'd2;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0] cipher_byte;
        logic       last_out;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_FILL,
        ST_IDLE,
        ST_KS_RD_I,
        ST_KS_RD_J,
        ST_KS_WR_I,
        ST_KS_WR_J,
        ST_EN_RD_I,
        ST_EN_RD_J,
        ST_EN_WR_I,
        ST_EN_WR_J,
        ST_EN_RD_K,
        ST_EN_OUT
    } state_t;

endpackage

// ===== src/rc4v_ram.sv =====
module rc4v_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AddrW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AddrW-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port, and a registered read that holds when not enabled
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/rc4_variant_stream_cipher_core.sv =====
// Encrypt word: accepted in idle, then five ordered accesses to the single-read, single-write
// permutation memory and the output state, which loads the output register once it is free;
// only back in the idle state is the next word taken.
// Init word: an identity fill, then 256 key-schedule steps, each reading and swapping two entries
// (s_ready returns after the last step); init produces no output word.
// Reset (aresetn low, synchronous): an identity fill of the memory then runs with
// s_ready low; configuration writes are taken throughout the fill.
module rc4_variant_stream_cipher_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rc4v_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output rc4v_pkg::out_word_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data
);
    import rc4v_pkg::*;

    state_t     state_reg, state_next;
    logic       init_flag_reg, init_flag_next;
    logic [7:0] n_reg, n_next;
    logic [3:0] key_idx_reg, key_idx_next;
    logic [7:0] i_reg, i_next;
    logic [7:0] j_reg, j_next;
    logic [7:0] si_reg, si_next;
    logic [8:0] sum_reg, sum_next;
    logic [7:0] data_reg, data_next;
    logic       last_reg, last_next;
    logic [63:0] key_low_reg, key_high_reg;
    logic [4:0]  key_len_reg;
    logic        out_valid_reg, out_valid_next;
    out_word_t   out_data_reg, out_data_next;

    logic         mem_we, mem_re;
    logic [7:0]   mem_waddr, mem_wdata, mem_raddr, mem_rdata;
    logic [4:0]   used_len;
    logic [127:0] key_all;
    logic [7:0]   key_byte;
    logic [7:0]   j_step;
    logic [8:0]   pair_sum;
    logic         s_fire, out_free;

    rc4v_ram #(.WIDTH(8), .DEPTH(256)) u_perm_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;
    assign out_free  = !out_valid_reg || m_ready;

    // clamp key length into 1..MAX_KEY_BYTES
    always_comb begin
        if (key_len_reg == 5'd0) begin
            used_len = 5'd1;
        end else if (key_len_reg > 5'(MAX_KEY_BYTES)) begin
            used_len = 5'(MAX_KEY_BYTES);
        end else begin
            used_len = key_len_reg;
        end
    end

    assign key_all  = {key_high_reg, key_low_reg};
    assign key_byte = key_all[{key_idx_reg, 3'b000} +: 8];
    assign j_step   = j_reg + mem_rdata + (key_byte ^ n_reg);
    assign pair_sum = {1'b0, mem_rdata} + {1'b0, si_reg};

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_FILL: begin
                if (n_reg == 8'hFF) begin
                    state_next = init_flag_reg ? ST_KS_RD_I : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = (s_data.opcode == OP_INIT) ? ST_FILL : ST_EN_RD_I;
                end
            end
            ST_KS_RD_I: state_next = ST_KS_RD_J;
            ST_KS_RD_J: state_next = ST_KS_WR_I;
            ST_KS_WR_I: state_next = ST_KS_WR_J;
            ST_KS_WR_J: state_next = (n_reg == 8'hFF) ? ST_IDLE : ST_KS_RD_I;
            ST_EN_RD_I: state_next = ST_EN_RD_J;
            ST_EN_RD_J: state_next = ST_EN_WR_I;
            ST_EN_WR_I: state_next = ST_EN_WR_J;
            ST_EN_WR_J: state_next = ST_EN_RD_K;
            ST_EN_RD_K: state_next = ST_EN_OUT;
            ST_EN_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // memory accesses and datapath updates
    always_comb begin
        mem_we         = 1'b0;
        mem_waddr      = n_reg;
        mem_wdata      = n_reg;
        mem_re         = 1'b0;
        mem_raddr      = n_reg;
        init_flag_next = init_flag_reg;
        n_next         = n_reg;
        key_idx_next   = key_idx_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        si_next        = si_reg;
        sum_next       = sum_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        case (state_reg)
            ST_FILL: begin
                // write identity, one entry a cycle
                mem_we = 1'b1;
                n_next = n_reg + 8'd1;
                if (n_reg == 8'hFF) begin
                    j_next       = 8'd0;
                    key_idx_next = 4'd0;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    data_next = s_data.data_byte;
                    last_next = s_data.last_byte;
                    if (s_data.opcode == OP_INIT) begin
                        init_flag_next = 1'b1;
                        n_next         = 8'd0;
                    end else begin
                        i_next = i_reg + 8'd1;
                    end
                end
            end
            ST_KS_RD_I: begin
                mem_re    = 1'b1;
                mem_raddr = n_reg;
            end
            ST_KS_RD_J: begin
                // mix in the key byte and fetch the partner entry
                j_next    = j_step;
                si_next   = mem_rdata;
                mem_re    = 1'b1;
                mem_raddr = j_step;
            end
            ST_KS_WR_I: begin
                mem_we    = 1'b1;
                mem_waddr = n_reg;
                mem_wdata = mem_rdata;
            end
            ST_KS_WR_J: begin
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                mem_wdata = si_reg;
                n_next    = n_reg + 8'd1;
                if ({1'b0, key_idx_reg} == used_len - 5'd1) begin
                    key_idx_next = 4'd0;
                end else begin
                    key_idx_next = key_idx_reg + 4'd1;
                end
                if (n_reg == 8'hFF) begin
                    i_next         = 8'd0;
                    init_flag_next = 1'b0;
                end
            end
            ST_EN_RD_I: begin
                mem_re    = 1'b1;
                mem_raddr = i_reg;
            end
            ST_EN_RD_J: begin
                j_next    = j_reg + mem_rdata;
                si_next   = mem_rdata;
                mem_re    = 1'b1;
                mem_raddr = j_reg + mem_rdata;
            end
            ST_EN_WR_I: begin
                // swap first half, and first reduction step of the keystream index
                mem_we    = 1'b1;
                mem_waddr = i_reg;
                mem_wdata = mem_rdata;
                sum_next  = (pair_sum >= 9'(KS_MODULUS)) ? pair_sum - 9'(KS_MODULUS)
                                                         : pair_sum;
            end
            ST_EN_WR_J: begin
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                mem_wdata = si_reg;
                sum_next  = (sum_reg >= 9'(KS_MODULUS)) ? sum_reg - 9'(KS_MODULUS)
                                                        : sum_reg;
            end
            ST_EN_RD_K: begin
                mem_re    = 1'b1;
                mem_raddr = sum_reg[7:0];
            end
            ST_EN_OUT: begin
                // hold until the output register is free
                if (out_free) begin
                    out_valid_next            = 1'b1;
                    out_data_next.cipher_byte = data_reg ^ mem_rdata;
                    out_data_next.last_out    = last_reg;
                end
            end
            default: ;
        endcase
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_FILL;
            init_flag_reg <= 1'b0;
            n_reg         <= 8'd0;
            key_idx_reg   <= 4'd0;
            i_reg         <= 8'd0;
            j_reg         <= 8'd0;
            out_valid_reg <= 1'b0;
            key_low_reg   <= 64'd0;
            key_high_reg  <= 64'd0;
            key_len_reg   <= 5'd1;
        end else begin
            state_reg     <= state_next;
            init_flag_reg <= init_flag_next;
            n_reg         <= n_next;
            key_idx_reg   <= key_idx_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_KEY_LOW:  key_low_reg  <= cfg_data;
                    REG_KEY_HIGH: key_high_reg <= cfg_data;
                    REG_KEY_LEN:  key_len_reg  <= cfg_data[4:0];
                    default: ;
                endcase
            end
        end
        si_reg       <= si_next;
        sum_reg      <= sum_next;
        data_reg     <= data_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ===== src/rc4v_checker.sv =====
module rc4v_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input rc4v_pkg::in_word_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input rc4v_pkg::out_word_t m_data,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic [1:0]         cfg_index,
    input logic [63:0]        cfg_data
);
    import rc4v_pkg::*;

    // a stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output word changed while stalled");

    // the table fill keeps the input closed straight after reset
    a_reset_fill: assert property (@(posedge aclk)
        aresetn && $past(!aresetn) |-> !s_ready)
        else $error("input open during reset fill");

    // one word at a time
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input open while a word is in progress");

    // no output word can appear straight after an accepted input word
    a_no_early_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("output word too early");

    // configuration is always taken
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind rc4_variant_stream_cipher_core rc4v_checker u_checker (.*);
